// ----- sv/omo_pkg.sv -----
// Shared widths, constants and arithmetic helpers for the three-wheel omni odometry block.
package omo_pkg;

  localparam int COUNT_BITS_DEF = 16;
  localparam int ANGLE_BITS_DEF = 16;

  localparam int ENC_W     = 16;
  localparam int EL_W      = 20;
  localparam int CPR_W     = 16;
  localparam int DIST_W    = 22;
  localparam int CFG_W     = 22;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_CPR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CIRC = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CTR  = 2'd2;

  // wheel displacement numerator, merged sums, body displacement
  localparam int N_W  = 39;
  localparam int AX_W = 41;
  localparam int BX_W = 43;

  localparam int TRIG_W = 34;
  localparam int C20_W  = 22;
  localparam int Q15_W  = 16;

  localparam int NUM_BITS = 40;
  localparam int YAW_FRAC = 5;
  localparam int YAW_SH   = 20 + YAW_FRAC;
  // heading divisor is never below 2^24, which bounds the quotient
  localparam int QY_TRIM  = 24;
  localparam int DEN_W    = 64;
  localparam int D1_W     = 38;
  localparam int D2_W     = 18;
  localparam int CC_W     = 38;

  localparam logic [21:0] SQ3X3_Q19  = 22'd2724280;
  localparam logic [24:0] PI6_Q20    = 25'd19765192;
  localparam logic [15:0] RATE_SCALE = 16'd31250;
  localparam logic [15:0] VEL_SCALE  = 16'd62500;

  localparam logic signed [TRIG_W-1:0] INVK_Q30 = 34'sd652032874;
  localparam int CORDIC_STEPS = 24;

  localparam logic signed [TRIG_W-1:0] ONE_Q20 = 34'sd1048576;
  localparam logic signed [TRIG_W-1:0] Q15_MAX = 34'sd32767;
  localparam logic signed [TRIG_W-1:0] Q15_MIN = -34'sd32768;

  function automatic logic signed [TRIG_W-1:0] atan_q30(input logic [4:0] idx);
    logic signed [TRIG_W-1:0] a;
    unique case (idx)
      5'd0:  a = 34'sd536870912;
      5'd1:  a = 34'sd316933406;
      5'd2:  a = 34'sd167458907;
      5'd3:  a = 34'sd85004756;
      5'd4:  a = 34'sd42667331;
      5'd5:  a = 34'sd21354465;
      5'd6:  a = 34'sd10679838;
      5'd7:  a = 34'sd5340245;
      5'd8:  a = 34'sd2670163;
      5'd9:  a = 34'sd1335087;
      5'd10: a = 34'sd667544;
      5'd11: a = 34'sd333772;
      5'd12: a = 34'sd166886;
      5'd13: a = 34'sd83443;
      5'd14: a = 34'sd41722;
      5'd15: a = 34'sd20861;
      5'd16: a = 34'sd10430;
      5'd17: a = 34'sd5215;
      5'd18: a = 34'sd2608;
      5'd19: a = 34'sd1304;
      5'd20: a = 34'sd652;
      5'd21: a = 34'sd326;
      5'd22: a = 34'sd163;
      5'd23: a = 34'sd81;
      default: a = '0;
    endcase
    return a;
  endfunction

  // round Q30 to Q20, clamp to +-1
  function automatic logic signed [C20_W-1:0] rnd_q20(input logic signed [TRIG_W-1:0] v);
    logic signed [TRIG_W-1:0] t;
    t = (v + 34'sd512) >>> 10;
    if (t > ONE_Q20) t = ONE_Q20;
    else if (t < -ONE_Q20) t = -ONE_Q20;
    return C20_W'(t);
  endfunction

  // round Q30 to Q15, saturate
  function automatic logic signed [Q15_W-1:0] rnd_q15(input logic signed [TRIG_W-1:0] v);
    logic signed [TRIG_W-1:0] t;
    t = (v + 34'sd16384) >>> 15;
    if (t > Q15_MAX) t = Q15_MAX;
    else if (t < Q15_MIN) t = Q15_MIN;
    return Q15_W'(t);
  endfunction

  // apply sign to a magnitude and saturate to 32 bits
  function automatic logic [31:0] sat32(input logic neg, input logic [63:0] mag);
    logic [31:0] r;
    if (!neg) r = (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    else      r = (mag > 64'h8000_0000) ? 32'h8000_0000 : 32'(64'd0 - mag);
    return r;
  endfunction

endpackage

// ----- sv/three_wheel_omni_odometry.sv -----
// Top level of the three-wheel omni odometry block.
//
// Takes one sample of three wheel encoder counts and the elapsed time, and returns the
// updated world position, heading, body velocities, yaw rate and heading quaternion.
// The first sample after reset only latches the counts and gives no transaction on the
// output. Every later sample runs through three wheel lanes and a merge stage, two
// CORDIC passes of 24 steps each and six divisions on one shared bit-serial divider
// of 65 + ANGLE_BITS bits (the rate division is skipped when the heading step
// saturates the yaw rate). The block takes a new sample only when idle, after the last
// result has been emitted. A finished result waits in the output register while the
// next sample is taken and processed. Write configuration only while the block is idle.
module three_wheel_omni_odometry #(
  parameter int COUNT_BITS = omo_pkg::COUNT_BITS_DEF,
  parameter int ANGLE_BITS = omo_pkg::ANGLE_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // enc_a [15:0], enc_b [31:16], enc_c [47:32], elapsed_us [67:48], zero pad [71:68]
  input  logic [71:0]                     s_axis_tdata,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // pos_x_um [31:0], pos_y_um [63:32], heading_out [79:64], vel_x_um_s [111:80],
  // vel_y_um_s [143:112], yaw_rate [175:144], quat_z [191:176], quat_w [207:192]
  output logic [207:0]                    m_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic                            cfg_we_i,
  input  logic [omo_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [omo_pkg::CFG_W-1:0]       cfg_data_i
);

  localparam int NUM_W = omo_pkg::NUM_BITS + ANGLE_BITS + omo_pkg::YAW_SH;
  localparam int QY_W  = NUM_W - omo_pkg::QY_TRIM;
  localparam int P_W   = omo_pkg::C20_W + omo_pkg::BX_W;
  localparam int PS_W  = P_W + 1;
  localparam logic signed [PS_W-1:0] HALF_UM = PS_W'(8388608);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_SUM   = 4'd1;
  localparam logic [3:0] ST_DH    = 4'd2;
  localparam logic [3:0] ST_COR_H = 4'd3;
  localparam logic [3:0] ST_COR_Q = 4'd4;
  localparam logic [3:0] ST_DV_BX = 4'd5;
  localparam logic [3:0] ST_DV_BY = 4'd6;
  localparam logic [3:0] ST_DV_QY = 4'd7;
  localparam logic [3:0] ST_DV_RT = 4'd8;
  localparam logic [3:0] ST_DV_VX = 4'd9;
  localparam logic [3:0] ST_DV_VY = 4'd10;
  localparam logic [3:0] ST_MUL1  = 4'd11;
  localparam logic [3:0] ST_MUL2  = 4'd12;
  localparam logic [3:0] ST_MUL3  = 4'd13;
  localparam logic [3:0] ST_EMIT  = 4'd14;

  // control and architectural state
  logic [3:0]                    state_q;
  logic                          go_q, started_q, m_valid_q;
  logic [omo_pkg::CPR_W-1:0]     cpr_q;
  logic [omo_pkg::DIST_W-1:0]    circ_q, ctr_q;
  logic [31:0]                   pos_x_q, pos_y_q;
  logic [ANGLE_BITS-1:0]         heading_q;

  // per-sample working registers
  logic [omo_pkg::EL_W-1:0]      el_q;
  logic [omo_pkg::D1_W-1:0]      d1_q;
  logic [omo_pkg::D2_W-1:0]      d2_q;
  logic [omo_pkg::CC_W-1:0]      cc_q;
  logic [omo_pkg::DEN_W-1:0]     dh_q;
  logic signed [omo_pkg::BX_W-1:0]  bx_q, by_q;
  logic [QY_W-1:0]               qy_q;
  logic [31:0]                   rate_q, vx_q, vy_q;
  logic signed [omo_pkg::C20_W-1:0] c20_q, s20_q;
  logic signed [omo_pkg::Q15_W-1:0] qz_q, qw_q;
  logic signed [P_W-1:0]         pa_q, pb_q;
  logic [207:0]                  out_q;

  logic                          acc, emit, unit_done, qy_big;
  logic [omo_pkg::CPR_W-1:0]     cpr_e;
  logic [omo_pkg::DIST_W-1:0]    ctr_e;
  logic [omo_pkg::EL_W-1:0]      el_in;
  logic signed [omo_pkg::N_W-1:0]  n0, n1, n2;
  logic signed [omo_pkg::AX_W-1:0] ax, ay, msum;
  logic [omo_pkg::AX_W-1:0]      ax_mag, ay_mag, m_mag;
  logic [omo_pkg::BX_W-1:0]      bx_mag, by_mag;
  logic                          ax_neg, ay_neg, m_neg, bx_neg, by_neg;
  logic                          div_start, div_done, cor_start, cor_done;
  logic [NUM_W-1:0]              div_num, div_quo;
  logic [omo_pkg::DEN_W-1:0]     div_den;
  logic [31:0]                   cor_ang, ang_head, ang_half, hs_ext;
  logic signed [omo_pkg::TRIG_W-1:0] cor_cos, cor_sin;
  logic signed [omo_pkg::BX_W-1:0]   quo_s;
  logic [QY_W-1:0]               qy_rnd;
  logic [ANGLE_BITS-1:0]         du;
  logic signed [PS_W-1:0]        psum;
  logic [31:0]                   pstep;

  assign el_in = s_axis_tdata[67:48];
  assign acc   = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);

  // zero divisors count as one
  assign cpr_e = (cpr_q == '0) ? omo_pkg::CPR_W'(1) : cpr_q;
  assign ctr_e = (ctr_q == '0) ? omo_pkg::DIST_W'(1) : ctr_q;

  // wheel lanes: every accepted sample moves the reference counts
  omo_lane #(.COUNT_BITS(COUNT_BITS)) u_lane_a (
    .clk_i, .rst_ni, .en_i(acc), .cnt_i(s_axis_tdata[15:0]), .circ_i(circ_q), .n_o(n0)
  );
  omo_lane #(.COUNT_BITS(COUNT_BITS)) u_lane_b (
    .clk_i, .rst_ni, .en_i(acc), .cnt_i(s_axis_tdata[31:16]), .circ_i(circ_q), .n_o(n1)
  );
  omo_lane #(.COUNT_BITS(COUNT_BITS)) u_lane_c (
    .clk_i, .rst_ni, .en_i(acc), .cnt_i(s_axis_tdata[47:32]), .circ_i(circ_q), .n_o(n2)
  );

  omo_merge u_merge (
    .clk_i, .en_i(state_q == ST_SUM), .n0_i(n0), .n1_i(n1), .n2_i(n2),
    .ax_o(ax), .ay_o(ay), .m_o(msum)
  );

  assign ax_neg = ax[omo_pkg::AX_W-1];
  assign ay_neg = ay[omo_pkg::AX_W-1];
  assign m_neg  = msum[omo_pkg::AX_W-1];
  assign bx_neg = bx_q[omo_pkg::BX_W-1];
  assign by_neg = by_q[omo_pkg::BX_W-1];
  assign ax_mag = ax_neg ? omo_pkg::AX_W'(-ax) : omo_pkg::AX_W'(ax);
  assign ay_mag = ay_neg ? omo_pkg::AX_W'(-ay) : omo_pkg::AX_W'(ay);
  assign m_mag  = m_neg ? omo_pkg::AX_W'(-msum) : omo_pkg::AX_W'(msum);
  assign bx_mag = bx_neg ? omo_pkg::BX_W'(-bx_q) : omo_pkg::BX_W'(bx_q);
  assign by_mag = by_neg ? omo_pkg::BX_W'(-by_q) : omo_pkg::BX_W'(by_q);

  // heading angles for the rotation and for the half-angle quaternion;
  // the most negative heading stands for +pi
  assign ang_head = 32'(heading_q) << (32 - ANGLE_BITS);
  assign hs_ext   = 32'($signed(heading_q));
  assign ang_half = (heading_q == {1'b1, {(ANGLE_BITS-1){1'b0}}}) ? 32'h4000_0000
                                                                  : hs_ext << (31 - ANGLE_BITS);
  assign cor_ang  = (state_q == ST_COR_H) ? ang_head : ang_half;
  assign cor_start = ((state_q == ST_COR_H) || (state_q == ST_COR_Q)) && !go_q;

  omo_cordic u_cordic (
    .clk_i, .rst_ni, .start_i(cor_start), .ang_i(cor_ang),
    .done_o(cor_done), .cos_o(cor_cos), .sin_o(cor_sin)
  );

  assign qy_big = |qy_q[QY_W-1:omo_pkg::NUM_BITS];

  // divider operands; rounded divisions add half the divisor up front
  always_comb begin
    div_num = '0;
    div_den = omo_pkg::DEN_W'(1);
    unique case (state_q)
      ST_DV_BX: begin
        div_num = (NUM_W'(ax_mag) << 23) + NUM_W'(d1_q >> 1);
        div_den = omo_pkg::DEN_W'(d1_q);
      end
      ST_DV_BY: begin
        div_num = (NUM_W'(ay_mag) << 4) + NUM_W'(d2_q >> 1);
        div_den = omo_pkg::DEN_W'(d2_q);
      end
      ST_DV_QY: begin
        div_num = NUM_W'(m_mag) << (ANGLE_BITS + omo_pkg::YAW_SH);
        div_den = dh_q;
      end
      ST_DV_RT: begin
        div_num = NUM_W'(qy_q[omo_pkg::NUM_BITS-1:0]) * NUM_W'(omo_pkg::RATE_SCALE)
                + NUM_W'(el_q >> 1);
        div_den = omo_pkg::DEN_W'(el_q);
      end
      ST_DV_VX: begin
        div_num = NUM_W'(bx_mag) * NUM_W'(omo_pkg::VEL_SCALE) + NUM_W'(el_q >> 1);
        div_den = omo_pkg::DEN_W'(el_q);
      end
      ST_DV_VY: begin
        div_num = NUM_W'(by_mag) * NUM_W'(omo_pkg::VEL_SCALE) + NUM_W'(el_q >> 1);
        div_den = omo_pkg::DEN_W'(el_q);
      end
      default: begin
        div_num = '0;
        div_den = omo_pkg::DEN_W'(1);
      end
    endcase
  end

  assign div_start = !go_q && (((state_q >= ST_DV_BX) && (state_q <= ST_DV_VY)) &&
                               !((state_q == ST_DV_RT) && qy_big));

  omo_div #(.NUM_W(NUM_W)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quo_o(div_quo)
  );

  assign quo_s     = $signed(omo_pkg::BX_W'(div_quo));
  assign unit_done = div_done || cor_done;

  // heading step: round the five fraction bits, ties up in magnitude
  assign qy_rnd = div_quo[QY_W-1:0] + QY_W'(16);
  assign du     = ANGLE_BITS'(qy_rnd >> omo_pkg::YAW_FRAC);

  // world step: round the Q24 product to whole micrometres, ties toward +inf
  assign psum  = (state_q == ST_MUL2) ? (PS_W'(pa_q) - PS_W'(pb_q))
                                      : (PS_W'(pa_q) + PS_W'(pb_q));
  assign pstep = 32'((psum + HALF_UM) >>> 24);

  assign emit = (state_q == ST_EMIT) && (!m_valid_q || m_axis_tready);

  // control: sequencer, configuration, pose
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      go_q      <= 1'b0;
      started_q <= 1'b0;
      m_valid_q <= 1'b0;
      cpr_q     <= 16'd4096;
      circ_q    <= 22'd188496;
      ctr_q     <= 22'd150000;
      pos_x_q   <= '0;
      pos_y_q   <= '0;
      heading_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          omo_pkg::REG_CPR:  cpr_q  <= cfg_data_i[omo_pkg::CPR_W-1:0];
          omo_pkg::REG_CIRC: circ_q <= cfg_data_i[omo_pkg::DIST_W-1:0];
          omo_pkg::REG_CTR:  ctr_q  <= cfg_data_i[omo_pkg::DIST_W-1:0];
          default: ;
        endcase
      end

      if (emit) m_valid_q <= 1'b1;
      else if (m_axis_tready) m_valid_q <= 1'b0;

      unique case (state_q)
        ST_IDLE: begin
          // first sample only latches the reference counts
          if (acc) begin
            if (!started_q) started_q <= 1'b1;
            else state_q <= ST_SUM;
          end
        end
        ST_SUM:  state_q <= ST_DH;
        ST_DH:   state_q <= ST_COR_H;
        ST_COR_H, ST_COR_Q, ST_DV_BX, ST_DV_BY, ST_DV_QY, ST_DV_VX, ST_DV_VY,
        ST_DV_RT: begin
          if ((state_q == ST_DV_RT) && qy_big) begin
            state_q <= ST_DV_VX;
          end else if (!go_q) begin
            go_q <= 1'b1;
          end else if (unit_done) begin
            go_q    <= 1'b0;
            state_q <= state_q + 4'd1;
            if (state_q == ST_DV_QY) begin
              heading_q <= m_neg ? (heading_q - du) : (heading_q + du);
            end
          end
        end
        ST_MUL1: state_q <= ST_MUL2;
        ST_MUL2: begin
          pos_x_q <= pos_x_q + pstep;
          state_q <= ST_MUL3;
        end
        ST_MUL3: begin
          pos_y_q <= pos_y_q + pstep;
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath: capture unit results as each step completes
  always_ff @(posedge clk_i) begin
    if (acc) begin
      el_q <= (el_in == '0) ? omo_pkg::EL_W'(1) : el_in;
    end
    if (state_q == ST_SUM) begin
      d1_q <= omo_pkg::D1_W'(cpr_e) * omo_pkg::D1_W'(omo_pkg::SQ3X3_Q19);
      d2_q <= omo_pkg::D2_W'(cpr_e) * omo_pkg::D2_W'(3);
      cc_q <= omo_pkg::CC_W'(cpr_e) * omo_pkg::CC_W'(ctr_e);
    end
    if (state_q == ST_DH) begin
      dh_q <= omo_pkg::DEN_W'(cc_q) * omo_pkg::DEN_W'(omo_pkg::PI6_Q20);
    end
    if (go_q && cor_done && (state_q == ST_COR_H)) begin
      c20_q <= omo_pkg::rnd_q20(cor_cos);
      s20_q <= omo_pkg::rnd_q20(cor_sin);
    end
    if (go_q && cor_done && (state_q == ST_COR_Q)) begin
      qz_q <= omo_pkg::rnd_q15(cor_sin);
      qw_q <= omo_pkg::rnd_q15(cor_cos);
    end
    if (go_q && div_done) begin
      unique case (state_q)
        ST_DV_BX: bx_q   <= ax_neg ? -quo_s : quo_s;
        ST_DV_BY: by_q   <= ay_neg ? -quo_s : quo_s;
        ST_DV_QY: qy_q   <= div_quo[QY_W-1:0];
        ST_DV_RT: rate_q <= omo_pkg::sat32(m_neg, div_quo[63:0]);
        ST_DV_VX: vx_q   <= omo_pkg::sat32(bx_neg, div_quo[63:0]);
        ST_DV_VY: vy_q   <= omo_pkg::sat32(by_neg, div_quo[63:0]);
        default: ;
      endcase
    end
    if ((state_q == ST_DV_RT) && qy_big) begin
      rate_q <= omo_pkg::sat32(m_neg, 64'h7FFF_FFFF);
    end
    if (state_q == ST_MUL1) begin
      pa_q <= P_W'(c20_q) * P_W'(bx_q);
      pb_q <= P_W'(s20_q) * P_W'(by_q);
    end
    if (state_q == ST_MUL2) begin
      pa_q <= P_W'(s20_q) * P_W'(bx_q);
      pb_q <= P_W'(c20_q) * P_W'(by_q);
    end
    if (emit) begin
      out_q <= {qw_q, qz_q, rate_q, vy_q, vx_q, 16'($signed(heading_q)), pos_y_q, pos_x_q};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_q;

endmodule

// ----- sv/omo_lane.sv -----
// One wheel lane: wrapped count delta and signed wheel displacement numerator.
module omo_lane #(
  parameter int COUNT_BITS = omo_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic [omo_pkg::ENC_W-1:0]           cnt_i,
  input  logic [omo_pkg::DIST_W-1:0]          circ_i,
  output logic signed [omo_pkg::N_W-1:0]      n_o
);

  localparam int CW = (COUNT_BITS < omo_pkg::ENC_W) ? COUNT_BITS : omo_pkg::ENC_W;

  logic [omo_pkg::ENC_W-1:0]        prev_q;
  logic [omo_pkg::ENC_W-1:0]        diff;
  logic signed [omo_pkg::ENC_W-1:0] ds;
  logic signed [omo_pkg::N_W-1:0]   prod;
  logic signed [omo_pkg::N_W-1:0]   n_q;

  assign diff = cnt_i - prev_q;
  assign ds   = omo_pkg::ENC_W'($signed(diff[CW-1:0]));
  assign prod = omo_pkg::N_W'(ds) * omo_pkg::N_W'($signed({1'b0, circ_i}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else if (en_i) begin
      prev_q <= cnt_i;
    end
  end

  // encoder counts run against the displacement sense: negate
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q <= -prod;
    end
  end

  assign n_o = n_q;

endmodule

// ----- sv/omo_merge.sv -----
// Merge of the three lane displacements into the body-axis sums and the sum of all three.
module omo_merge (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic signed [omo_pkg::N_W-1:0]  n0_i,
  input  logic signed [omo_pkg::N_W-1:0]  n1_i,
  input  logic signed [omo_pkg::N_W-1:0]  n2_i,
  output logic signed [omo_pkg::AX_W-1:0] ax_o,
  output logic signed [omo_pkg::AX_W-1:0] ay_o,
  output logic signed [omo_pkg::AX_W-1:0] m_o
);

  logic signed [omo_pkg::AX_W-1:0] e0, e1, e2;
  logic signed [omo_pkg::AX_W-1:0] ax_q, ay_q, m_q;

  assign e0 = omo_pkg::AX_W'(n0_i);
  assign e1 = omo_pkg::AX_W'(n1_i);
  assign e2 = omo_pkg::AX_W'(n2_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax_q <= e0 + e0 - e1 - e2;
      ay_q <= e1 - e2;
      m_q  <= e0 + e1 + e2;
    end
  end

  assign ax_o = ax_q;
  assign ay_o = ay_q;
  assign m_o  = m_q;

endmodule

// ----- sv/omo_cordic.sv -----
// Iterative rotation-mode CORDIC: cos and sin of a 32-bit binary angle, Q30, one step a cycle.
module omo_cordic (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [31:0]                       ang_i,
  output logic                              done_o,
  output logic signed [omo_pkg::TRIG_W-1:0] cos_o,
  output logic signed [omo_pkg::TRIG_W-1:0] sin_o
);

  logic                              busy_q, done_q, flip_q;
  logic [4:0]                        cnt_q;
  logic signed [omo_pkg::TRIG_W-1:0] x_q, y_q, z_q;
  logic signed [omo_pkg::TRIG_W-1:0] xs, ys, at;
  logic [31:0]                       tst, ang_rot;
  logic                              flip;

  assign tst     = ang_i + 32'h4000_0000;
  assign flip    = tst[31];
  assign ang_rot = flip ? (ang_i + 32'h8000_0000) : ang_i;

  assign xs = x_q >>> cnt_q;
  assign ys = y_q >>> cnt_q;
  assign at = omo_pkg::atan_q30(cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'(omo_pkg::CORDIC_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      flip_q <= flip;
      x_q    <= omo_pkg::INVK_Q30;
      y_q    <= '0;
      z_q    <= omo_pkg::TRIG_W'($signed(ang_rot));
    end else if (busy_q) begin
      if (z_q >= 0) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + at;
      end
    end
  end

  assign done_o = done_q;
  assign cos_o  = flip_q ? -x_q : x_q;
  assign sin_o  = flip_q ? -y_q : y_q;

endmodule

// ----- sv/omo_div.sv -----
// Restoring unsigned divider, one quotient bit a cycle.
module omo_div #(
  parameter int NUM_W = 81
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [NUM_W-1:0]                 num_i,
  input  logic [omo_pkg::DEN_W-1:0]        den_i,
  output logic                             done_o,
  output logic [NUM_W-1:0]                 quo_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]          acc_q;
  logic [omo_pkg::DEN_W-1:0] rem_q, den_q;
  logic [CNT_W-1:0]          cnt_q;
  logic                      busy_q, done_q;
  logic [omo_pkg::DEN_W:0]   trial, diff;
  logic                      fit;

  assign trial = {rem_q, acc_q[NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fit   = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // quotient bits shift in behind the numerator bits
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= fit ? diff[omo_pkg::DEN_W-1:0] : trial[omo_pkg::DEN_W-1:0];
      acc_q <= {acc_q[NUM_W-2:0], fit};
    end
  end

  assign done_o = done_q;
  assign quo_o  = acc_q;

endmodule

// ----- dv/three_wheel_omni_odometry_checker.sv -----
// Scoreboard for the three-wheel omni odometry block: predicts each pose update and checks it.
module three_wheel_omni_odometry_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [71:0]                   s_axis_tdata,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic [207:0]                  m_axis_tdata,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic                          cfg_we_i,
  input  logic [omo_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [omo_pkg::CFG_W-1:0]     cfg_data_i,
  output int                            pending_o,
  output int                            fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [15:0] heading;
    logic [31:0] vel_x;
    logic [31:0] vel_y;
    logic [31:0] yaw_rate;
    logic [15:0] quat_z;
    logic [15:0] quat_w;
  } pose_t;

  localparam longint ARCTAN_Q30 [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81
  };
  localparam longint GAIN_Q30   = 652032874;
  localparam longint ROOT27_Q19 = 2724280;
  localparam longint SIXPI_Q20  = 19765192;
  localparam longint I32_MAX    = 64'sd2147483647;
  localparam longint I32_MIN    = -64'sd2147483648;

  logic [15:0] cpr_q, last_a, last_b, last_c, hdg_q;
  logic [21:0] circ_q, ctr_q;
  logic [31:0] px_q, py_q;
  logic        latched_q;
  pose_t       pose_fifo[$];
  int          fails;

  function automatic longint round_div(input longint num, input longint den);
    if (num >= 0) return (num + den / 2) / den;
    return -((-num + den / 2) / den);
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // CORDIC rotation of a 32-bit binary angle, results in Q30
  function automatic void cordic(input logic [31:0] ang, output longint cs, output longint sn);
    longint x, y, z, nx;
    bit     flip;
    x = GAIN_Q30;
    y = 0;
    flip = 1'b0;
    if (((ang + 32'h4000_0000) & 32'h8000_0000) != 0) begin
      ang = ang + 32'h8000_0000;
      flip = 1'b1;
    end
    z = longint'($signed(ang));
    for (int i = 0; i < 24; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - ARCTAN_Q30[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + ARCTAN_Q30[i];
      end
      x = nx;
    end
    cs = flip ? -x : x;
    sn = flip ? -y : y;
  endfunction

  // advance the odometry state by one sample; returns 0 for the reference sample
  function automatic bit update_pose(input logic [71:0] d, output pose_t p);
    logic [15:0]  cur [3];
    logic [15:0]  old [3];
    logic [15:0]  dl, du;
    logic [127:0] q128;
    logic [63:0]  qy, mag;
    logic [31:0]  half;
    longint n [3];
    longint cpr, ctr, el, ax, ay, m, bx, by, c, s, c20, s20, pr, hs, rate;
    cur[0] = d[15:0];
    cur[1] = d[31:16];
    cur[2] = d[47:32];
    p = '0;
    if (!latched_q) begin
      last_a = cur[0];
      last_b = cur[1];
      last_c = cur[2];
      latched_q = 1'b1;
      return 1'b0;
    end
    old[0] = last_a;
    old[1] = last_b;
    old[2] = last_c;
    cpr = (cpr_q == 0) ? 1 : longint'(cpr_q);
    ctr = (ctr_q == 0) ? 1 : longint'(ctr_q);
    el  = (d[67:48] == 0) ? 1 : longint'(d[67:48]);
    for (int i = 0; i < 3; i++) begin
      dl = cur[i] - old[i];
      n[i] = -longint'($signed(dl)) * longint'(circ_q);
    end
    last_a = cur[0];
    last_b = cur[1];
    last_c = cur[2];
    ax = 2 * n[0] - n[1] - n[2];
    ay = n[1] - n[2];
    m  = n[0] + n[1] + n[2];
    bx = round_div(ax * (64'sd1 <<< 23), cpr * ROOT27_Q19);
    by = round_div(ay * 16, 3 * cpr);

    // rotate the body step by the heading held before this sample
    cordic({hdg_q, 16'h0}, c, s);
    c20 = clip((c + 512) >>> 10, -(64'sd1 <<< 20), 64'sd1 <<< 20);
    s20 = clip((s + 512) >>> 10, -(64'sd1 <<< 20), 64'sd1 <<< 20);
    pr = c20 * bx - s20 * by;
    px_q = px_q + 32'((pr + (64'sd1 <<< 23)) >>> 24);
    pr = s20 * bx + c20 * by;
    py_q = py_q + 32'((pr + (64'sd1 <<< 23)) >>> 24);

    // half-angle quaternion; the most negative heading stands for +pi
    hs = longint'($signed(hdg_q));
    if (hdg_q == 16'h8000) half = 32'h4000_0000;
    else                   half = 32'(hs <<< 15);
    cordic(half, c, s);
    p.quat_z = 16'(clip((s + 16384) >>> 15, -32768, 32767));
    p.quat_w = 16'(clip((c + 16384) >>> 15, -32768, 32767));

    mag  = (m < 0) ? 64'(-m) : 64'(m);
    q128 = ({64'd0, mag} << 41) / (128'(cpr) * 128'(ctr) * 128'(SIXPI_Q20));
    qy   = q128[63:0];
    du   = 16'((qy + 64'd16) >> 5);
    if (m < 0) du = -du;
    hdg_q = hdg_q + du;
    if (qy >= (64'd1 << 40)) rate = I32_MAX;
    else                     rate = round_div(longint'(qy) * 31250, el);
    if (m < 0) rate = -rate;

    p.pos_x    = px_q;
    p.pos_y    = py_q;
    p.heading  = hdg_q;
    p.vel_x    = 32'(clip(round_div(bx * 62500, el), I32_MIN, I32_MAX));
    p.vel_y    = 32'(clip(round_div(by * 62500, el), I32_MIN, I32_MAX));
    p.yaw_rate = 32'(clip(rate, I32_MIN, I32_MAX));
    return 1'b1;
  endfunction

  function automatic void compare_field(input string nm, input logic [31:0] want,
                                        input logic [31:0] got);
    if (want !== got) begin
      fails++;
      if (fails <= 10)
        $display("mismatch %s: expected %h, got %h at %0t", nm, want, got, $realtime);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pose_t want, got;
    if (!rst_ni) begin
      cpr_q <= 16'd4096;
      circ_q <= 22'd188496;
      ctr_q <= 22'd150000;
      {last_a, last_b, last_c} <= '0;
      hdg_q <= '0;
      px_q <= '0;
      py_q <= '0;
      latched_q <= 1'b0;
      pose_fifo.delete();
      fails = 0;
      pending_o <= 0;
      fail_count_o <= 0;
    end else begin
      // retire first so a stray result cannot pair with a newly queued one
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{pos_x: m_axis_tdata[31:0], pos_y: m_axis_tdata[63:32],
                heading: m_axis_tdata[79:64], vel_x: m_axis_tdata[111:80],
                vel_y: m_axis_tdata[143:112], yaw_rate: m_axis_tdata[175:144],
                quat_z: m_axis_tdata[191:176], quat_w: m_axis_tdata[207:192]};
        if (pose_fifo.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result %h at %0t", m_axis_tdata, $realtime);
        end else begin
          want = pose_fifo.pop_front();
          compare_field("pos_x_um", want.pos_x, got.pos_x);
          compare_field("pos_y_um", want.pos_y, got.pos_y);
          compare_field("heading_out", 32'(want.heading), 32'(got.heading));
          compare_field("vel_x_um_s", want.vel_x, got.vel_x);
          compare_field("vel_y_um_s", want.vel_y, got.vel_y);
          compare_field("yaw_rate", want.yaw_rate, got.yaw_rate);
          compare_field("quat_z", 32'(want.quat_z), 32'(got.quat_z));
          compare_field("quat_w", 32'(want.quat_w), 32'(got.quat_w));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (update_pose(s_axis_tdata, want)) pose_fifo.push_back(want);
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          omo_pkg::REG_CPR:  cpr_q = cfg_data_i[15:0];
          omo_pkg::REG_CIRC: circ_q = cfg_data_i;
          omo_pkg::REG_CTR:  ctr_q = cfg_data_i;
          default: ;
        endcase
      end
      pending_o <= pose_fifo.size();
      fail_count_o <= fails;
    end
  end

endmodule

// ----- dv/three_wheel_omni_odometry_test.sv -----
// Top of the odometry testbench: clock, reset, stimulus, handshake pressure and verdict.
module three_wheel_omni_odometry_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 20000;  // cycles without any transaction
  localparam int SETTLE      = 700;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic [71:0]                   s_axis_tdata = '0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [207:0]                  m_axis_tdata;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic                          cfg_we_i = 1'b0;
  logic [omo_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [omo_pkg::CFG_W-1:0]     cfg_data_i = '0;
  int                            pending, fail_count, quiet_cycles;
  bit                            idle_en = 1'b1;
  bit                            hold_req = 1'b0;
  logic [15:0]                   wheel_a = '0, wheel_b = '0, wheel_c = '0;

  three_wheel_omni_odometry dut (.*);

  three_wheel_omni_odometry_checker scoreboard (
    .clk_i, .rst_ni, .s_axis_tdata, .s_axis_tvalid, .s_axis_tready,
    .m_axis_tdata, .m_axis_tvalid, .m_axis_tready, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .pending_o(pending), .fail_count_o(fail_count)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: give up once neither side has moved a transaction for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: random backpressure bursts, plus one long hold-off on request.
  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (3000) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (idle_en && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk_i);
      end
    end
  end

  // Offer one sample and hold it until taken; maybe leave a gap afterwards.
  task automatic send_sample(input logic [15:0] a, b, c, input logic [19:0] el);
    s_axis_tdata <= {4'b0, el, c, b, a};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    wheel_a = a;
    wheel_b = b;
    wheel_c = c;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
  endtask

  // Move the wheels by a random amount, shaped to cover slow, fast and wrapping motion.
  task automatic random_sample();
    int          kind;
    logic [15:0] da, db, dc;
    logic [19:0] el;
    kind = $urandom_range(0, 9);
    el = 20'($urandom_range(1, 20000));
    case (kind)
      0, 1, 2, 3, 4: begin
        da = 16'($urandom_range(0, 600) - 300);
        db = 16'($urandom_range(0, 600) - 300);
        dc = 16'($urandom_range(0, 600) - 300);
      end
      5, 6: begin
        da = 16'($urandom_range(0, 4000) - 2000);
        db = da;
        dc = da;
      end
      7: begin
        da = 16'($urandom);
        db = 16'($urandom);
        dc = 16'($urandom);
        el = 20'($urandom);
      end
      8: begin
        {da, db, dc} = '0;
        el = ($urandom_range(0, 1) == 1) ? 20'hFFFFF : 20'd0;
      end
      default: begin
        da = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        db = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        dc = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        el = 20'($urandom_range(0, 3));
      end
    endcase
    send_sample(wheel_a + da, wheel_b + db, wheel_c + dc, el);
  endtask

  // Drop valid and wait for every pending result, then let the block go quiet.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // One write, then a pause with the enable low so back-to-back writes never collide on it.
  task automatic write_reg(input logic [omo_pkg::CFG_IDX_W-1:0] idx,
                           input logic [omo_pkg::CFG_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_config(input logic [omo_pkg::CFG_W-1:0] cpr, circ, ctr);
    write_reg(omo_pkg::REG_CPR, cpr);
    write_reg(omo_pkg::REG_CIRC, circ);
    write_reg(omo_pkg::REG_CTR, ctr);
  endtask

  task automatic random_run(input int count);
    repeat (count) random_sample();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reference latch, extremes of counts and elapsed time, wrap both ways.
    send_sample(16'h7FFF, 16'h8000, 16'hFFFF, 20'd5);
    send_sample(16'h7FFF, 16'h8000, 16'hFFFF, 20'd1000);
    send_sample(16'h8000, 16'h8000, 16'hFFFF, 20'd1);
    send_sample(16'h7FFF, 16'h0000, 16'hFFFF, 20'hFFFFF);
    send_sample(16'h7FFF, 16'h0000, 16'h7FFE, 20'd0);
    send_sample(16'h0000, 16'hFFFF, 16'h0000, 20'd12345);
    send_sample(16'h0064, 16'h0063, 16'h0064, 20'd0);
    send_sample(16'h0000, 16'hFFFF, 16'h0000, 20'hFFFFF);
    send_sample(16'h8000, 16'h7FFF, 16'h8000, 20'd1);
    send_sample(16'h0000, 16'hFFFF, 16'h0000, 20'h80000);
    send_sample(16'h0100, 16'h0080, 16'h0080, 20'd1000);
    send_sample(16'h0100, 16'h0180, 16'h0000, 20'd1000);
    send_sample(16'h5555, 16'hAAAA, 16'h3333, 20'h55555);
    send_sample(16'hAAAA, 16'h5555, 16'hCCCC, 20'hAAAAA);
    random_run(180);
    // Pause the sender until every result is home, mid-run.
    drain();
    random_run(20);
    drain();

    // Smallest scale and centre distance: large heading steps and saturated rates.
    load_config(22'd1, 22'h3FFFFF, 22'd1);
    hold_req = 1'b1;  // long output stall while the sender keeps offering
    random_run(200);
    drain();

    load_config(22'd65535, 22'd1, 22'h3FFFFF);
    random_run(200);
    drain();

    // Zero scale and centre distance behave as one, zero circumference gives no motion; index 3 is ignored.
    load_config(22'd0, 22'd0, 22'd0);
    write_reg(2'd3, 22'h2AAAAA);
    random_run(100);
    drain();

    // Oversized scale value keeps only its low bits.
    load_config(22'h3F0010, 22'd1000, 22'd50);
    random_run(200);
    drain();

    repeat (3) begin
      load_config(22'($urandom_range(1, 65535)), 22'($urandom_range(1, 4194303)),
                  22'($urandom_range(1, 4194303)));
      random_run(200);
      drain();
    end

    // Closing stretch at full throughput on both sides.
    load_config(22'd4096, 22'd188496, 22'd150000);
    idle_en = 1'b0;
    random_run(250);
    drain();

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

// ----- files.f -----
sv/omo_pkg.sv
sv/omo_lane.sv
sv/omo_merge.sv
sv/omo_cordic.sv
sv/omo_div.sv
sv/three_wheel_omni_odometry.sv
dv/three_wheel_omni_odometry_checker.sv
dv/three_wheel_omni_odometry_test.sv
